/* hdl/circle_raster_canvas_defines.svh */
// assertion macros shared by the canvas rtl
`ifndef CIRCLE_RASTER_CANVAS_DEFINES_SVH
`define CIRCLE_RASTER_CANVAS_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define CRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/crc_pkg.sv */
// shared constants and codes of the circle raster canvas
`default_nettype none

package crc_pkg;

    localparam int CHAR_W     = 8;
    localparam int OP_W       = 2;
    localparam int COORD_W    = 20;
    localparam int RADIUS_W   = 19;
    localparam int IDX_W      = 8;
    localparam int IN_DATA_W  = 88;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 9'd256;
    localparam logic [CHAR_W-1:0]     BG_RESET     = 8'd32;

endpackage

`default_nettype wire

/* hdl/crc_canvas_mem.sv */
// character canvas store, one write and one registered read port
`default_nettype none

module crc_canvas_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [crc_pkg::CHAR_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [crc_pkg::CHAR_W-1:0] rd_data
);

    logic [crc_pkg::CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/crc_square.sv */
// registered squaring unit shared by the circle sequencer
`default_nettype none

module crc_square #(
    parameter int W = 21
) (
    input  wire logic                clk,
    input  wire logic signed [W-1:0] a,
    output logic         [2*W-1:0]   sq
);

    logic signed [2*W-1:0] prod;

    assign prod = a * a;

    always_ff @(posedge clk)
    begin
        sq <= $unsigned(prod);
    end

endmodule

`default_nettype wire

/* hdl/circle_raster_canvas.sv */
// top level: character canvas with clear, circle draw and cell read
// clear: one store write per cycle over the whole store
// draw: one cell per cycle, plus a row setup state before each row,
//   on the shared squarer, no sweep with no cell in use; zero radius or op 3 skips it all
// read: through the registered store read port
// one item at a time, a held result stalls it; reset clears control and config only
`default_nettype none
`include "circle_raster_canvas_defines.svh"

module circle_raster_canvas #(
    parameter int MAX_SIDE  = 256,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input beat
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // filled[0], center_x[20:1], center_y[40:21], radius[59:41],
    // paint_char[67:60], read_col[75:68], read_row[83:76], zero pad[87:84]
    input  wire logic [crc_pkg::IN_DATA_W-1:0]     s_tdata,
    // op[1:0]
    input  wire logic [crc_pkg::OP_W-1:0]          s_tuser,
    // result beat
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // cell_char[7:0]
    output logic      [crc_pkg::CHAR_W-1:0]        m_tdata,
    // error[0]
    output logic                                   m_tuser,
    // configuration write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [crc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [crc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = CW + 1;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    // signed width of a center offset: column term plus center range
    localparam int MW    = ((CW + FRAC_BITS) > 19 ? (CW + FRAC_BITS) : 19) + 2;
    localparam int PW    = 2 * MW;
    localparam logic signed [MW-1:0] ONE_FX = MW'(1) << FRAC_BITS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_SQ_R  = 9'b000000100,
        S_SQ_IN = 9'b000001000,
        S_ROW   = 9'b000010000,
        S_CELL  = 9'b000100000,
        S_DRAIN = 9'b001000000,
        S_READ  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    // what the squarer output holds this cycle
    typedef enum logic [2:0] {
        TAG_NONE = 3'd0,
        TAG_R2   = 3'd1,
        TAG_IN2  = 3'd2,
        TAG_DY2  = 3'd3,
        TAG_CELL = 3'd4
    } sq_tag_t;

    state_t                          state_reg, state_next;

    // captured item
    logic [crc_pkg::OP_W-1:0]        op_reg, op_next;
    logic                            filled_reg, filled_next;
    logic signed [crc_pkg::COORD_W-1:0] cx_reg, cx_next;
    logic signed [crc_pkg::COORD_W-1:0] cy_reg, cy_next;
    logic [crc_pkg::RADIUS_W-1:0]    radius_reg, radius_next;
    logic [crc_pkg::CHAR_W-1:0]      paint_reg, paint_next;
    logic [crc_pkg::IDX_W-1:0]       rd_col_reg, rd_col_next;
    logic [crc_pkg::IDX_W-1:0]       rd_row_reg, rd_row_next;
    logic                            err_reg, err_next;

    // sweep position and running offsets
    logic [CW-1:0]                   col_reg, col_next;
    logic [CW-1:0]                   row_reg, row_next;
    logic [AW-1:0]                   row_base_reg, row_base_next;
    logic [AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic signed [MW-1:0]            dx_reg, dx_next;
    logic signed [MW-1:0]            dy_reg, dy_next;
    logic                            ring_all_reg, ring_all_next;

    // squarer pipeline
    logic signed [MW-1:0]            mul_a;
    sq_tag_t                         mul_tag;
    logic [AW-1:0]                   mul_addr;
    logic [PW-1:0]                   prod;
    sq_tag_t                         prod_tag_reg;
    logic [AW-1:0]                   prod_addr_reg;
    logic [PW-1:0]                   r2_reg;
    logic [PW-1:0]                   inner2_reg;
    logic [PW-1:0]                   dy2_reg;
    logic [PW-1:0]                   d2;
    logic                            hit;
    logic                            cell_we;

    // config
    logic [crc_pkg::CFG_DATA_W-1:0]  cfg_w_reg;
    logic [crc_pkg::CFG_DATA_W-1:0]  cfg_h_reg;
    logic [crc_pkg::CHAR_W-1:0]      cfg_bg_reg;
    logic [SW-1:0]                   w_lim;
    logic [SW-1:0]                   h_lim;

    // store ports
    logic                            clr_we;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [crc_pkg::CHAR_W-1:0]      mem_wdata;
    logic                            mem_re;
    logic [AW-1:0]                   mem_raddr;
    logic [crc_pkg::CHAR_W-1:0]      mem_rdata;
    logic                            rd_in_range;

    // result register
    logic                            out_load;
    logic                            out_valid_reg, out_valid_next;
    logic [crc_pkg::CHAR_W-1:0]      out_char_reg;
    logic                            out_err_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_char_reg;
    assign m_tuser   = out_err_reg;

    // sizes in use saturate at the store side
    assign w_lim = ({23'd0, cfg_w_reg} > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cfg_w_reg);
    assign h_lim = ({23'd0, cfg_h_reg} > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cfg_h_reg);

    // read address, cells beyond the store read as zero
    assign rd_in_range = (32'(rd_col_reg) < 32'(MAX_SIDE)) && (32'(rd_row_reg) < 32'(MAX_SIDE));
    assign mem_raddr   = AW'(32'(rd_row_reg) * MAX_SIDE + 32'(rd_col_reg));

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        filled_next   = filled_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        radius_next   = radius_reg;
        paint_next    = paint_reg;
        rd_col_next   = rd_col_reg;
        rd_row_next   = rd_row_reg;
        err_next      = err_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        clr_addr_next = clr_addr_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        ring_all_next = ring_all_reg;
        mul_a         = '0;
        mul_tag       = TAG_NONE;
        mul_addr      = row_base_reg + AW'(col_reg);
        clr_we        = 1'b0;
        mem_re        = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    filled_next = s_tdata[0];
                    cx_next     = $signed(s_tdata[20:1]);
                    cy_next     = $signed(s_tdata[40:21]);
                    radius_next = s_tdata[59:41];
                    paint_next  = s_tdata[67:60];
                    rd_col_next = s_tdata[75:68];
                    rd_row_next = s_tdata[83:76];
                    err_next    = 1'b0;
                    case (s_tuser)
                        crc_pkg::OP_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        crc_pkg::OP_DRAW:
                        begin
                            if (s_tdata[59:41] == '0)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SQ_R;
                            end
                        end
                        crc_pkg::OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                clr_we = 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            S_SQ_R:
            begin
                mul_a         = $signed(MW'(radius_reg));
                mul_tag       = TAG_R2;
                // below one cell, every covered cell is on the outline
                ring_all_next = 32'(radius_reg) < (32'd1 << FRAC_BITS);
                state_next    = S_SQ_IN;
            end
            S_SQ_IN:
            begin
                mul_a         = $signed(MW'(radius_reg)) - ONE_FX;
                mul_tag       = TAG_IN2;
                row_next      = '0;
                row_base_next = '0;
                dy_next       = -MW'(cy_reg);
                if ((w_lim == '0) || (h_lim == '0))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                mul_a      = dy_reg;
                mul_tag    = TAG_DY2;
                dx_next    = -MW'(cx_reg);
                col_next   = '0;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                mul_a    = dx_reg;
                mul_tag  = TAG_CELL;
                dx_next  = dx_reg + ONE_FX;
                col_next = col_reg + CW'(1);
                if ((SW'(col_reg) + SW'(1)) == w_lim)
                begin
                    col_next = '0;
                    if ((SW'(row_reg) + SW'(1)) == h_lim)
                    begin
                        row_next      = '0;
                        row_base_next = '0;
                        state_next    = S_DRAIN;
                    end
                    else
                    begin
                        row_next      = row_reg + CW'(1);
                        row_base_next = row_base_reg + AW'(MAX_SIDE);
                        dy_next       = dy_reg + ONE_FX;
                        state_next    = S_ROW;
                    end
                end
            end
            S_DRAIN:
            begin
                // last cell leaves the squarer here
                state_next = S_DONE;
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    crc_square #(
        .W (MW)
    ) u_square (
        .clk (clk),
        .a   (mul_a),
        .sq  (prod)
    );

    // cell test on the squared distance, no root taken
    assign d2      = prod + dy2_reg;
    assign hit     = (d2 <= r2_reg) && (filled_reg || ring_all_reg || (d2 > inner2_reg));
    assign cell_we = (prod_tag_reg == TAG_CELL) && hit;

    assign mem_we    = clr_we || cell_we;
    assign mem_waddr = cell_we ? prod_addr_reg : clr_addr_reg;
    assign mem_wdata = cell_we ? paint_reg : cfg_bg_reg;

    crc_canvas_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_canvas (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign out_valid_next = (out_valid_reg && !m_tready) || out_load;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
            clr_addr_reg  <= '0;
            prod_tag_reg  <= TAG_NONE;
            out_valid_reg <= 1'b0;
            cfg_w_reg     <= crc_pkg::WIDTH_RESET;
            cfg_h_reg     <= crc_pkg::HEIGHT_RESET;
            cfg_bg_reg    <= crc_pkg::BG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_base_reg  <= row_base_next;
            clr_addr_reg  <= clr_addr_next;
            prod_tag_reg  <= mul_tag;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    crc_pkg::CFG_WIDTH:  cfg_w_reg  <= cfg_data;
                    crc_pkg::CFG_HEIGHT: cfg_h_reg  <= cfg_data;
                    crc_pkg::CFG_BG:     cfg_bg_reg <= cfg_data[crc_pkg::CHAR_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        filled_reg    <= filled_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        radius_reg    <= radius_next;
        paint_reg     <= paint_next;
        rd_col_reg    <= rd_col_next;
        rd_row_reg    <= rd_row_next;
        err_reg       <= err_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        ring_all_reg  <= ring_all_next;
        prod_addr_reg <= mul_addr;
        case (prod_tag_reg)
            TAG_R2:  r2_reg     <= prod;
            TAG_IN2: inner2_reg <= prod;
            TAG_DY2: dy2_reg    <= prod;
            default: ;
        endcase
        if (out_load)
        begin
            out_char_reg <= ((op_reg == crc_pkg::OP_READ) && rd_in_range) ? mem_rdata : '0;
            out_err_reg  <= err_reg;
        end
    end

    // store is only written while an item is at work
    `CRC_ASSERT_NOW(a_wr_when_busy, clk, rst_n, mem_we, !s_tready, "canvas write while idle")

    // a cell in the squarer output is always drained before the result
    `CRC_ASSERT_NOW(a_cell_drained, clk, rst_n, prod_tag_reg == TAG_CELL,
        (state_reg == S_CELL) || (state_reg == S_ROW) || (state_reg == S_DRAIN),
        "cell product outside the sweep")

    // an accepted beat makes the block busy
    `CRC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "ready stayed high after an accepted beat")

endmodule

`default_nettype wire

/* tb/tb_circle_raster_canvas.sv */
`timescale 1ns / 100ps
// self-checking testbench for the circle raster canvas: clear, draw and read beats
module tb_circle_raster_canvas;

    localparam int OP_W       = crc_pkg::OP_W;
    localparam int CFG_IDX_W  = crc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = crc_pkg::CFG_DATA_W;
    localparam int CHAR_W     = crc_pkg::CHAR_W;
    localparam int COORD_W    = crc_pkg::COORD_W;
    localparam int RADIUS_W   = crc_pkg::RADIUS_W;
    localparam int IDX_W      = crc_pkg::IDX_W;
    localparam int IN_DATA_W  = crc_pkg::IN_DATA_W;

    // op and register codes that the package leaves out
    localparam logic [OP_W-1:0]      OP_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int SIDE         = 256;
    localparam int FRAC         = 8;
    localparam int IDLE_PCT     = 19;
    // a clear or a full size draw moves no beat until its result
    localparam int STALL_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 15;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                filled;
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [RADIUS_W-1:0] radius;
        logic [CHAR_W-1:0]   paint_char;
        logic [IDX_W-1:0]    read_col;
        logic [IDX_W-1:0]    read_row;
    } circle_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic              error;
    } cell_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [CHAR_W-1:0]     m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow of the block: canvas contents and the three registers
    bit   [CHAR_W-1:0]     canvas_shadow [0:SIDE*SIDE-1];
    logic [CFG_DATA_W-1:0] shadow_width  = crc_pkg::WIDTH_RESET;
    logic [CFG_DATA_W-1:0] shadow_height = crc_pkg::HEIGHT_RESET;
    logic [CHAR_W-1:0]     shadow_bg     = crc_pkg::BG_RESET;

    cell_result_t expected_cells [$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    // both sides stay busy while this is set
    bit           no_idle        = 1'b0;

    circle_raster_canvas u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // apply one item to the shadow canvas and return the result beat it causes
    function automatic cell_result_t apply_canvas_item(input circle_item_t it);
        cell_result_t res;
        int           w;
        int           h;
        longint       r;
        longint       r2;
        longint       inner;
        longint       inner2;
        longint       cx;
        longint       cy;
        longint       dx;
        longint       dy;
        longint       d2;
        bit           ring_all;
        res = '0;
        case (it.op)
            crc_pkg::OP_CLEAR:
            begin
                // the whole store, also cells outside the size in use
                for (int k = 0; k < SIDE * SIDE; k++)
                    canvas_shadow[k] = shadow_bg;
            end
            crc_pkg::OP_DRAW:
            begin
                if (it.radius == '0)
                    res.error = 1'b1;
                else
                begin
                    // size registers saturate at the store side
                    w        = (shadow_width > SIDE) ? SIDE : int'(shadow_width);
                    h        = (shadow_height > SIDE) ? SIDE : int'(shadow_height);
                    r        = longint'(it.radius);
                    r2       = r * r;
                    inner    = r - (longint'(1) << FRAC);
                    // radius below one: every covered cell is outline
                    ring_all = (inner < 0);
                    inner2   = ring_all ? 0 : inner * inner;
                    cx       = longint'($signed(it.center_x));
                    cy       = longint'($signed(it.center_y));
                    for (int row = 0; row < h; row++)
                    begin
                        dy = (longint'(row) << FRAC) - cy;
                        for (int col = 0; col < w; col++)
                        begin
                            dx = (longint'(col) << FRAC) - cx;
                            d2 = dx * dx + dy * dy;
                            if (d2 <= r2 && (it.filled || ring_all || d2 > inner2))
                                canvas_shadow[row * SIDE + col] = it.paint_char;
                        end
                    end
                end
            end
            crc_pkg::OP_READ:
                res.cell_char = canvas_shadow[{it.read_row, it.read_col}];
            default:
                ;
        endcase
        return res;
    endfunction

    // item with every field random, op as given
    function automatic circle_item_t noise_item(input logic [OP_W-1:0] op);
        circle_item_t it;
        it.op         = op;
        it.filled     = 1'($urandom_range(0, 1));
        it.center_x   = COORD_W'($urandom);
        it.center_y   = COORD_W'($urandom);
        it.radius     = RADIUS_W'($urandom);
        it.paint_char = CHAR_W'($urandom);
        it.read_col   = IDX_W'($urandom);
        it.read_row   = IDX_W'($urandom);
        return it;
    endfunction

    function automatic circle_item_t draw_item(input logic filled, input int cx, input int cy,
                                               input int radius, input int ch);
        circle_item_t it;
        it            = noise_item(crc_pkg::OP_DRAW);
        it.filled     = filled;
        it.center_x   = COORD_W'(cx);
        it.center_y   = COORD_W'(cy);
        it.radius     = RADIUS_W'(radius);
        it.paint_char = CHAR_W'(ch);
        return it;
    endfunction

    function automatic circle_item_t read_item(input int col, input int row);
        circle_item_t it;
        it          = noise_item(crc_pkg::OP_READ);
        it.read_col = IDX_W'(col);
        it.read_row = IDX_W'(row);
        return it;
    endfunction

    // mostly well-formed draws and reads inside the canvas in use, some noise
    function automatic circle_item_t random_item(input int w_eff, input int h_eff);
        circle_item_t it;
        int           roll;
        int           r_roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            it = noise_item(crc_pkg::OP_DRAW);
            if ($urandom_range(0, 4) != 0)
            begin
                it.center_x = COORD_W'($urandom_range(0, w_eff - 1) * SIDE
                                       + $urandom_range(0, 255));
                it.center_y = COORD_W'($urandom_range(0, h_eff - 1) * SIDE
                                       + $urandom_range(0, 255));
            end
            r_roll = $urandom_range(0, 19);
            if (r_roll == 0)
                it.radius = '0;
            else if (r_roll > 2)
                it.radius = RADIUS_W'($urandom_range(1, 8 * SIDE));
        end
        else if (roll < 92)
        begin
            it = noise_item(crc_pkg::OP_READ);
            if ($urandom_range(0, 4) != 0)
            begin
                it.read_col = IDX_W'($urandom_range(0, w_eff - 1));
                it.read_row = IDX_W'($urandom_range(0, h_eff - 1));
            end
        end
        else
            it = noise_item(OP_NONE);
        return it;
    endfunction

    // one input beat; valid stays up across back-to-back beats
    task automatic send_item(input circle_item_t it);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {4'b0, it.read_row, it.read_col, it.paint_char, it.radius,
                     it.center_y, it.center_x, it.filled};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_cells.push_back(apply_canvas_item(it));
    endtask

    // stop sending and let every expected result come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_cells.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            crc_pkg::CFG_WIDTH:  shadow_width  = CFG_DATA_W'(val);
            crc_pkg::CFG_HEIGHT: shadow_height = CFG_DATA_W'(val);
            crc_pkg::CFG_BG:     shadow_bg     = CHAR_W'(val);
            default:             ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_canvas(input int w, input int h, input int bg);
        wait_idle();
        write_reg(crc_pkg::CFG_WIDTH, w);
        write_reg(crc_pkg::CFG_HEIGHT, h);
        write_reg(crc_pkg::CFG_BG, bg);
    endtask

    // reset sizes and background, one full size draw
    task automatic test_reset_defaults();
        send_item(noise_item(crc_pkg::OP_CLEAR));
        send_item(read_item(0, 0));
        send_item(draw_item(1'b1, 128 * SIDE, 128 * SIDE, 100 * SIDE, 8'h23));
        send_item(read_item(128, 128));
        send_item(read_item(255, 255));
    endtask

    // one cell canvas, empty canvas, oversized width
    task automatic test_size_extremes();
        set_canvas(1, 1, 0);
        // unused index must change nothing
        write_reg(CFG_SPARE, $urandom_range(0, 511));
        send_item(noise_item(crc_pkg::OP_CLEAR));
        send_item(draw_item(1'b1, 0, 0, (1 << RADIUS_W) - 1, 8'hFF));
        send_item(read_item(0, 0));
        send_item(read_item(1, 0));
        // zero width: nothing in use, nothing painted
        set_canvas(0, 5, 0);
        send_item(draw_item(1'b1, 0, 0, (1 << RADIUS_W) - 1, 8'h07));
        send_item(read_item(0, 0));
        // width beyond the store saturates
        set_canvas(511, 2, 0);
        send_item(draw_item(1'b1, 200 * SIDE, 1 * SIDE, 10 * SIDE, "C"));
        send_item(read_item(205, 1));
        send_item(read_item(0, 0));
    endtask

    // zero radius, op 3, tiny radii, outline ring, extreme centers
    task automatic test_special_draws();
        set_canvas(16, 16, 255);
        send_item(noise_item(crc_pkg::OP_CLEAR));
        send_item(draw_item(1'b1, 4 * SIDE, 4 * SIDE, 0, "C"));
        send_item(noise_item(OP_NONE));
        // radius one: the four neighbors, not the center
        send_item(draw_item(1'b0, 5 * SIDE, 5 * SIDE, SIDE, "c"));
        // radius below one: only the exact center cell
        send_item(draw_item(1'b0, 10 * SIDE, 10 * SIDE, 1, "C"));
        send_item(draw_item(1'b0, 8 * SIDE, 8 * SIDE, 6 * SIDE + 128, 8'h00));
        send_item(draw_item(1'b1, -(1 << (COORD_W - 1)), (1 << (COORD_W - 1)) - 1,
                            (1 << RADIUS_W) - 1, 8'h01));
        send_item(read_item(5, 5));
        send_item(read_item(6, 5));
        send_item(read_item(10, 10));
        send_item(read_item(8, 2));
        send_item(read_item(255, 255));
    endtask

    // phases of random items, each with its own canvas setting
    task automatic test_random_phases();
        int w;
        int h;
        int w_eff;
        int h_eff;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    w = $urandom_range(1, 16);
                    h = $urandom_range(1, 16);
                end
                1:
                begin
                    w = $urandom_range(192, 511);
                    h = $urandom_range(1, 3);
                end
                2:
                begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(192, 511);
                end
                3:
                begin
                    w = $urandom_range(0, 511);
                    h = $urandom_range(0, 4);
                end
                default:
                begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 24);
                end
            endcase
            set_canvas(w, h, $urandom_range(0, 255));
            w_eff   = (w < 1) ? 1 : ((w > SIDE) ? SIDE : w);
            h_eff   = (h < 1) ? 1 : ((h > SIDE) ? SIDE : h);
            // the wide phase runs with no idling on either side
            no_idle = (phase == 1);
            if (phase == 0 || phase == 3)
                send_item(noise_item(crc_pkg::OP_CLEAR));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item(w_eff, h_eff));
        end
        no_idle = 1'b0;
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        cell_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("unexpected result beat: cell_char %0d error %0d", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = expected_cells.pop_front();
                if (m_tdata !== want.cell_char)
                begin
                    $error("cell_char expected %0d actual %0d", want.cell_char, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.error)
                begin
                    $error("error expected %0d actual %0d", want.error, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_size_extremes();
        test_special_draws();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/crc_pkg.sv
hdl/crc_canvas_mem.sv
hdl/crc_square.sv
hdl/circle_raster_canvas.sv
tb/tb_circle_raster_canvas.sv
